FILE: design/rhsv_pkg.sv
// Types, codes and the division step shared by the RGB to HSV pipeline.
// Depends on nothing; imported by rhsv_prep and rgb_to_hsv_convert.
`default_nettype none

package rhsv_pkg;

	// Restoring division steps done between two pipeline registers;
	// three such stages give the nine-bit quotient
	localparam int unsigned DIV_STEPS_PER_STAGE = 3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
	} pixel_t;

	typedef struct packed {
		logic [10:0] hue;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
		logic        frame_end_out;
	} hsv_t;

	// Which channel is largest and the sign of the hue difference
	typedef enum logic [2:0] {
		SEC_GREY,
		SEC_RED_POS,
		SEC_RED_NEG,
		SEC_GREEN_POS,
		SEC_GREEN_NEG,
		SEC_BLUE_POS,
		SEC_BLUE_NEG
	} sector_t;

	// Partial state of one restoring divider; remainder stays below the divisor
	typedef struct packed {
		logic [7:0] rem;
		logic [8:0] num;
		logic [8:0] quot;
	} div_t;

	typedef struct packed {
		sector_t    sector;
		logic [7:0] span;
		logic [7:0] peak;
		logic       frame_end;
	} side_t;

	typedef struct packed {
		side_t side;
		div_t  hdiv;
		div_t  sdiv;
	} stage_t;

	function automatic div_t div_step(div_t s, logic [7:0] den);
		logic [8:0] t;
		div_t       r;
		t      = {s.rem, s.num[8]};
		r.num  = {s.num[7:0], 1'b0};
		if (t >= {1'b0, den}) begin
			r.rem  = 8'(t - {1'b0, den});
			r.quot = {s.quot[7:0], 1'b1};
		end else begin
			r.rem  = t[7:0];
			r.quot = {s.quot[7:0], 1'b0};
		end
		return r;
	endfunction

	// Advance both dividers of one pipeline stage
	function automatic stage_t div_stage(stage_t s);
		stage_t r;
		r = s;
		for (int unsigned i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
			r.hdiv = div_step(r.hdiv, s.side.span);
			r.sdiv = div_step(r.sdiv, s.side.peak);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/rhsv_prep.sv
// Front stage logic: max, min, hue sector and the two divider start states.
// Depends on rhsv_pkg.
`default_nettype none

module rhsv_prep
	import rhsv_pkg::*;
(
	input  pixel_t pixel,
	output stage_t prep
);

	logic [7:0]  peak;
	logic [7:0]  low;
	logic [7:0]  span;
	logic [7:0]  hdelta;
	logic [15:0] sat_num;
	sector_t     sector;

	always_comb begin
		peak = (pixel.red > pixel.green) ? pixel.red : pixel.green;
		if (pixel.blue > peak) begin
			peak = pixel.blue;
		end
		low = (pixel.red < pixel.green) ? pixel.red : pixel.green;
		if (pixel.blue < low) begin
			low = pixel.blue;
		end
		span = peak - low;

		// Red wins ties, then green
		if (span == 8'd0) begin
			sector = SEC_GREY;
			hdelta = 8'd0;
		end else if (peak == pixel.red) begin
			sector = (pixel.green >= pixel.blue) ? SEC_RED_POS : SEC_RED_NEG;
			hdelta = (pixel.green >= pixel.blue) ? pixel.green - pixel.blue
				: pixel.blue - pixel.green;
		end else if (peak == pixel.green) begin
			sector = (pixel.blue >= pixel.red) ? SEC_GREEN_POS : SEC_GREEN_NEG;
			hdelta = (pixel.blue >= pixel.red) ? pixel.blue - pixel.red
				: pixel.red - pixel.blue;
		end else begin
			sector = (pixel.red >= pixel.green) ? SEC_BLUE_POS : SEC_BLUE_NEG;
			hdelta = (pixel.red >= pixel.green) ? pixel.red - pixel.green
				: pixel.green - pixel.red;
		end

		// 255*span as span*256 - span
		sat_num = {span, 8'h00} - {8'h00, span};

		prep.side.sector    = sector;
		prep.side.span      = span;
		prep.side.peak      = peak;
		prep.side.frame_end = pixel.frame_end;
		// Dividend hdelta*256; quotient fits in nine bits
		prep.hdiv.rem  = {1'b0, hdelta[7:1]};
		prep.hdiv.num  = {hdelta[0], 8'h00};
		prep.hdiv.quot = 9'd0;
		prep.sdiv.rem  = {1'b0, sat_num[15:9]};
		prep.sdiv.num  = sat_num[8:0];
		prep.sdiv.quot = 9'd0;
	end

endmodule

`default_nettype wire

FILE: design/rgb_to_hsv_convert.sv
// A pixel is registered in st_s1, st_s2, st_s3, st_s4 and hsv_s5 before hsv_valid.
// Throughput: one pixel per cycle unless hsv_ready stalls the output; the
// nine-step restoring dividers run three steps per stage over three stages.
// Each stage advances when it is empty or the next one advances.
// Reset clears all stage valid bits; payload registers are not reset.
// Depends on rhsv_pkg and rhsv_prep.
`default_nettype none

module rgb_to_hsv_convert
	import rhsv_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pixel_valid,
	output logic   pixel_ready,
	input  pixel_t pixel,
	output logic   hsv_valid,
	input  logic   hsv_ready,
	output hsv_t   hsv
);

	stage_t prep;
	stage_t st_s1, st_s2, st_s3, st_s4;
	logic   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic   en_s1, en_s2, en_s3, en_s4, en_s5;
	hsv_t   res;
	hsv_t   hsv_s5;
	logic [9:0]  hceil;
	logic [11:0] hue_w;

	rhsv_prep u_prep (
		.pixel (pixel),
		.prep  (prep)
	);

	assign en_s5       = !v_s5 || hsv_ready;
	assign en_s4       = !v_s4 || en_s5;
	assign en_s3       = !v_s3 || en_s4;
	assign en_s2       = !v_s2 || en_s3;
	assign en_s1       = !v_s1 || en_s2;
	assign pixel_ready = en_s1;

	always_comb begin
		hceil = {1'b0, st_s4.hdiv.quot} + {9'd0, (st_s4.hdiv.rem != 8'd0)};
		unique case (st_s4.side.sector)
			SEC_GREY:      hue_w = 12'd0;
			SEC_RED_POS:   hue_w = {3'd0, st_s4.hdiv.quot};
			SEC_RED_NEG:   hue_w = 12'd1536 - {2'd0, hceil};
			SEC_GREEN_POS: hue_w = 12'd512 + {3'd0, st_s4.hdiv.quot};
			SEC_GREEN_NEG: hue_w = 12'd512 - {2'd0, hceil};
			SEC_BLUE_POS:  hue_w = 12'd1024 + {3'd0, st_s4.hdiv.quot};
			SEC_BLUE_NEG:  hue_w = 12'd1024 - {2'd0, hceil};
			default:       hue_w = 12'd0;
		endcase
		res.hue           = hue_w[10:0];
		res.saturation    = (st_s4.side.sector == SEC_GREY) ? 8'd0
			: st_s4.sdiv.quot[7:0];
		res.brightness    = st_s4.side.peak;
		res.frame_end_out = st_s4.side.frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pixel_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// Payload: load only when the stage advances and new data is valid
	always_ff @(posedge clk) begin
		if (en_s1 && pixel_valid) st_s1 <= prep;
		if (en_s2 && v_s1) st_s2 <= div_stage(st_s1);
		if (en_s3 && v_s2) st_s3 <= div_stage(st_s2);
		if (en_s4 && v_s3) st_s4 <= div_stage(st_s3);
		if (en_s5 && v_s4) hsv_s5 <= res;
	end

	assign hsv_valid = v_s5;
	assign hsv       = hsv_s5;

	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv.saturation == 8'd0 |-> hsv.hue == 11'd0)
		else $error("grey pixel with nonzero hue");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hsv.hue <= 11'd1535)
		else $error("hue out of range");

	a_sat_peak: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && hsv.saturation != 8'd0 |-> hsv.brightness != 8'd0)
		else $error("saturation without brightness");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && st_s4.side.sector != SEC_GREY
			|-> st_s4.hdiv.rem < st_s4.side.span && st_s4.sdiv.rem < st_s4.side.peak)
		else $error("divider remainder not below divisor");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> pixel_ready)
		else $error("empty front stage refuses a transaction");

endmodule

`default_nettype wire
